>>> rtl/core/max_paired_dot_product_defines.svh
// Assertion macros shared by the files that check their own logic.
`ifndef MAX_PAIRED_DOT_PRODUCT_DEFINES_SVH
`define MAX_PAIRED_DOT_PRODUCT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define MPDP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A registered condition must be followed by the given consequence.
`define MPDP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mpdp_pkg.sv
package mpdp_pkg;
    localparam int MaxItems   = 1024;
    localparam int ValueWidth = 18;
    localparam int OutWidth   = 46;
    localparam int AddrWidth  = $clog2(MaxItems);
    localparam int CountWidth = AddrWidth + 1;

    typedef logic [AddrWidth-1:0]  t_addr;
    typedef logic [CountWidth-1:0] t_count;
    typedef logic signed [ValueWidth-1:0] t_value;

    typedef struct packed {
        logic   load;
        logic   clear_acc;
        logic   rd_sel_j;
        logic   wr_en;
        logic   copy_wr;
        logic   mac_en;
        t_addr  rd_addr;
        t_addr  wr_addr;
        logic   take_hold;
        logic   flush_j;
    } t_cmd;

    typedef struct packed {
        logic less;
    } t_status;
endpackage

>>> rtl/core/mpdp_datapath.sv
module mpdp_datapath (
    input  logic                             i_clk,
    input  mpdp_pkg::t_cmd                   i_cmd,
    input  mpdp_pkg::t_addr                  i_load_addr,
    input  mpdp_pkg::t_value                 i_a,
    input  mpdp_pkg::t_value                 i_b,
    output mpdp_pkg::t_status                o_status,
    output logic signed [mpdp_pkg::OutWidth-1:0] o_acc
);
    import mpdp_pkg::*;

    // List A is sorted first and list B after it through the same merge
    // logic; the list select picks which memory is read and written back.
    logic [ValueWidth-1:0] r_mem_a [MaxItems];
    logic [ValueWidth-1:0] r_mem_b [MaxItems];
    logic [ValueWidth-1:0] r_scr   [MaxItems];
    logic [ValueWidth-1:0] r_rd_a;
    logic [ValueWidth-1:0] r_rd_b;
    logic [ValueWidth-1:0] r_rd_s;
    logic [ValueWidth-1:0] r_hold;
    logic signed [2*ValueWidth-1:0] r_prod;
    logic signed [OutWidth-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem_a[i_load_addr] <= i_a;
            r_mem_b[i_load_addr] <= i_b;
        end else if (i_cmd.copy_wr) begin
            if (i_cmd.rd_sel_j) begin
                r_mem_b[i_cmd.wr_addr] <= r_rd_s;
            end else begin
                r_mem_a[i_cmd.wr_addr] <= r_rd_s;
            end
        end
        if (i_cmd.wr_en) begin
            r_scr[i_cmd.wr_addr] <= i_cmd.flush_j ? r_rd_a : r_hold;
        end
        r_rd_a <= i_cmd.rd_sel_j ? r_mem_b[i_cmd.rd_addr] : r_mem_a[i_cmd.rd_addr];
        r_rd_b <= r_mem_b[i_cmd.rd_addr];
        r_rd_s <= r_scr[i_cmd.rd_addr];
        if (i_cmd.take_hold) begin
            r_hold <= r_rd_a;
        end
        r_prod <= $signed(r_rd_a) * $signed(r_rd_b);
        if (i_cmd.clear_acc) begin
            r_acc <= '0;
        end else if (i_cmd.mac_en) begin
            r_acc <= r_acc + OutWidth'(r_prod);
        end
    end

    assign o_status.less = $signed(r_rd_a) < $signed(r_hold);
    assign o_acc = r_acc;
endmodule

>>> rtl/core/mpdp_ctrl.sv
module mpdp_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  mpdp_pkg::t_count       i_count,
    input  mpdp_pkg::t_status      i_status,
    output mpdp_pkg::t_cmd         o_cmd,
    output logic                   o_done
);
    import mpdp_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PASS  = 11'b00000000010,
        S_RDI   = 11'b00000000100,
        S_WAITI = 11'b00000001000,
        S_RDJ   = 11'b00000010000,
        S_WAITJ = 11'b00000100000,
        S_CMP   = 11'b00001000000,
        S_COPY  = 11'b00010000000,
        S_MAC   = 11'b00100000000,
        S_DRAIN = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_list, n_list;
    t_count r_width, n_width, r_lo, n_lo, r_i, n_i, r_j, n_j, r_k, n_k;
    t_count r_mid, n_mid, r_hi, n_hi;
    logic   r_have_i, n_have_i;
    t_count r_cp, n_cp;
    logic [1:0] r_drain, n_drain;
    t_count w_mid, w_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_list  <= 1'b0;
            r_width <= '0;
            r_lo    <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_mid   <= '0;
            r_hi    <= '0;
            r_have_i <= 1'b0;
            r_cp    <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_list  <= n_list;
            r_width <= n_width;
            r_lo    <= n_lo;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_mid   <= n_mid;
            r_hi    <= n_hi;
            r_have_i <= n_have_i;
            r_cp    <= n_cp;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        logic [CountWidth:0] w_mid_sum;
        logic [CountWidth:0] w_hi_sum;
        w_mid_sum = {1'b0, r_lo} + {1'b0, r_width};
        w_mid = (w_mid_sum < {1'b0, i_count}) ? w_mid_sum[CountWidth-1:0] : i_count;
        w_hi_sum = {1'b0, w_mid} + {1'b0, r_width};
        w_hi = (w_hi_sum < {1'b0, i_count}) ? w_hi_sum[CountWidth-1:0] : i_count;
    end

    // Merge step: element i is held in a register; element j is read and
    // compared. The smaller is written to scratch, then the next is read.
    always_comb begin
        n_state = r_state;
        n_list = r_list;
        n_width = r_width;
        n_lo = r_lo;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_mid = r_mid;
        n_hi = r_hi;
        n_have_i = r_have_i;
        n_cp = r_cp;
        n_drain = r_drain;
        o_cmd = '0;
        o_done = 1'b0;
        o_cmd.rd_sel_j = r_list;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_list = 1'b0;
                    n_width = t_count'(1);
                    n_lo = '0;
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                if (r_width >= i_count) begin
                    if (r_list) begin
                        n_cp = '0;
                        n_state = S_MAC;
                        o_cmd.clear_acc = 1'b1;
                    end else begin
                        n_list = 1'b1;
                        n_width = t_count'(1);
                        n_lo = '0;
                    end
                end else if (r_lo >= i_count) begin
                    n_cp = '0;
                    n_state = S_COPY;
                end else begin
                    n_mid = w_mid;
                    n_hi = w_hi;
                    n_i = r_lo;
                    n_j = w_mid;
                    n_k = r_lo;
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                if (r_i < r_mid) begin
                    o_cmd.rd_addr = r_i[AddrWidth-1:0];
                    n_state = S_WAITI;
                end else begin
                    n_have_i = 1'b0;
                    n_state = S_RDJ;
                end
            end
            S_WAITI: begin
                o_cmd.take_hold = 1'b1;
                n_have_i = 1'b1;
                n_state = S_RDJ;
            end
            S_RDJ: begin
                if (r_j < r_hi) begin
                    o_cmd.rd_addr = r_j[AddrWidth-1:0];
                    n_state = S_WAITJ;
                end else if (r_have_i) begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.wr_addr = r_k[AddrWidth-1:0];
                    n_k = r_k + 1'b1;
                    n_i = r_i + 1'b1;
                    n_state = S_RDI;
                end else begin
                    n_lo = r_hi;
                    n_state = S_PASS;
                end
            end
            S_WAITJ: begin
                o_cmd.rd_addr = r_j[AddrWidth-1:0];
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_addr = r_k[AddrWidth-1:0];
                n_k = r_k + 1'b1;
                if (r_have_i && !i_status.less) begin
                    n_i = r_i + 1'b1;
                    n_state = S_RDI;
                end else begin
                    o_cmd.flush_j = 1'b1;
                    n_j = r_j + 1'b1;
                    n_state = S_RDJ;
                end
            end
            S_COPY: begin
                o_cmd.rd_addr = r_cp[AddrWidth-1:0];
                o_cmd.copy_wr = (r_cp != '0);
                o_cmd.wr_addr = AddrWidth'(r_cp - 1'b1);
                if (r_cp == i_count) begin
                    n_width = r_width << 1;
                    n_lo = '0;
                    n_state = S_PASS;
                end else begin
                    n_cp = r_cp + 1'b1;
                end
            end
            S_MAC: begin
                o_cmd.rd_sel_j = 1'b0;
                o_cmd.rd_addr = r_cp[AddrWidth-1:0];
                o_cmd.mac_en = (r_cp > t_count'(1));
                n_cp = r_cp + 1'b1;
                if (r_cp == i_count) begin
                    n_drain = 2'd1;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.mac_en = 1'b1;
                n_drain = r_drain - 1'b1;
                if (r_drain == 2'd1 || i_count == t_count'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> rtl/core/max_paired_dot_product.sv
// Streams in pairs of signed values, one transfer per cycle while idle, up to
// 1024 pairs; the transfer with tlast closes the set. The controller then merge
// sorts both lists in turn through block memories and a scratch memory, with a
// copy back after each of the log2(n) merge passes, and accumulates the products
// of equal-rank elements in one more sweep. Input is stalled from the tlast
// transfer until the result transfer is taken.
`include "max_paired_dot_product_defines.svh"
module max_paired_dot_product (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // a_value [17:0], b_value [35:18], zero fill
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // dot_product [45:0], dropped [46], zero fill
);
    import mpdp_pkg::*;

    mpdp_pkg::t_cmd    w_cmd, w_dp_cmd;
    mpdp_pkg::t_status w_status;
    logic signed [OutWidth-1:0] w_acc;
    logic   w_done, w_start, w_acc_in, w_full;
    t_count r_count;
    logic   r_over, r_busy, r_out_v;
    logic [OutWidth-1:0] r_out_d;
    logic   r_out_drop;

    assign s_axis_tready = !r_busy && !r_out_v;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;
    assign w_full = (r_count == t_count'(MaxItems));
    assign w_start = w_acc_in && s_axis_tlast;

    always_comb begin
        w_dp_cmd = w_cmd;
        w_dp_cmd.load = w_acc_in && !w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_over <= 1'b0;
            r_busy <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_acc_in && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            if (w_acc_in && w_full) begin
                r_over <= 1'b1;
            end
            if (w_start) begin
                r_busy <= 1'b1;
            end
            if (w_done) begin
                r_busy <= 1'b0;
                r_out_v <= 1'b1;
                r_count <= '0;
                r_over <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_d <= w_acc;
            r_out_drop <= r_over;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {1'b0, r_out_drop, r_out_d};

    mpdp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_count (w_full ? r_count : r_count + t_count'(!w_full && w_start)),
        .i_status(w_status),
        .o_cmd   (w_cmd),
        .o_done  (w_done)
    );

    mpdp_datapath u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_dp_cmd),
        .i_load_addr(r_count[AddrWidth-1:0]),
        .i_a        (s_axis_tdata[17:0]),
        .i_b        (s_axis_tdata[35:18]),
        .o_status   (w_status),
        .o_acc      (w_acc)
    );

    `MPDP_ASSERT(a_no_accept_busy, !(r_busy && s_axis_tready), "input taken while busy")
    `MPDP_ASSERT(a_count_cap, r_count <= t_count'(MaxItems), "pair count beyond capacity")
    `MPDP_ASSERT_NEXT(a_done_out, w_done, m_axis_tvalid && !r_busy, "result not presented")
endmodule
